// ===== rtl/core/ptt_pkg.sv =====
// ============================================================================
// ptt_pkg - preorder tree table types and constants
// Shared types, codes and sizes for the cell chain and its controller.
// ============================================================================
`default_nettype none
package ptt_pkg;

    localparam int MAX_NODES = 64;
    localparam int ID_BITS   = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int DEP_W     = 6;
    localparam int VAL_W     = 16;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [ID_BITS-1:0] par;
        logic [DEP_W-1:0]   dep;
    } entry_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] node_id;
        logic [15:0] new_parent;
        logic [5:0]  child_sel;
    } in_word_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  status;
        logic [15:0] value;
    } out_word_t;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_SETPAR  = 3'd2,
        OP_CHCOUNT = 3'd3,
        OP_DESC    = 3'd4,
        OP_NTH     = 3'd5,
        OP_PARENT  = 3'd6,
        OP_UNUSED  = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_ILLEGAL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_ROT,
        CM_SHL,
        CM_SHR,
        CM_WR
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t       mode;
        logic [IDX_W-1:0] lo;
        entry_t           wr;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHL,
        S_SHR,
        S_WRITE,
        S_RESP
    } fsm_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptt_cell.sv =====
// ============================================================================
// ptt_cell - one table entry of the chain
// Holds, rotates, shifts or loads its entry as the broadcast control says.
// ============================================================================
`default_nettype none
module ptt_cell (
    input  wire                        aclk,
    input  ptt_pkg::cell_ctrl_t        ctrl,
    input  wire [ptt_pkg::IDX_W-1:0]   idx,
    input  ptt_pkg::entry_t            left,
    input  ptt_pkg::entry_t            right,
    output ptt_pkg::entry_t            q
);
    import ptt_pkg::*;

    entry_t q_reg;
    entry_t q_next;

    always_comb begin
        case (ctrl.mode)
            CM_ROT:  q_next = right;
            CM_SHL:  q_next = (idx >= ctrl.lo) ? right : q_reg;
            CM_SHR:  q_next = (idx > ctrl.lo) ? left : q_reg;
            CM_WR:   q_next = (idx == ctrl.lo) ? ctrl.wr : q_reg;
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ptt_chain.sv =====
// ============================================================================
// ptt_chain - ring of table cells
// Links the cells to their neighbours and exposes the head entry.
// ============================================================================
`default_nettype none
module ptt_chain (
    input  wire                 aclk,
    input  ptt_pkg::cell_ctrl_t ctrl,
    output ptt_pkg::entry_t     head
);
    import ptt_pkg::*;

    entry_t q [MAX_NODES];

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        ptt_cell u_cell (
            .aclk  (aclk),
            .ctrl  (ctrl),
            .idx   (IDX_W'(g)),
            .left  (q[(g + MAX_NODES - 1) % MAX_NODES]),
            .right (q[(g + 1) % MAX_NODES]),
            .q     (q[g])
        );
    end

    assign head = q[0];

endmodule
`default_nettype wire

// ===== rtl/core/preorder_tree_table_engine.sv =====
// ============================================================================
// preorder_tree_table_engine - tree kept as a preorder table
// Controller and cell ring for create, remove, move and tree queries.
// ============================================================================
// The tree sits in a ring of MAX_NODES cells in preorder, one entry per cell.
// One word is taken at a time. Create goes straight to the decide state and
// then to the result register. Every other opcode first rotates the ring once
// round, watching the head cell to find the node, its subtree run, the new
// parent and the direct children, then decides and publishes. Remove then
// shifts the subtree run out of the ring; a move closes the gap, opens one at
// the new place and writes the run back from a side buffer. A new word is
// accepted once the result of the previous one is in the output register.
`default_nettype none
module preorder_tree_table_engine (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  ptt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output ptt_pkg::out_word_t m_data
);
    import ptt_pkg::*;

    // control state
    fsm_t             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_BITS-1:0] idctr_reg, idctr_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             f_at_reg, f_at_next;
    logic             in_run_reg, in_run_next;
    logic             cfound_reg, cfound_next;
    logic             pf_reg, pf_next;
    logic             m_valid_reg, m_valid_next;

    // payload state
    in_word_t         in_reg, in_next;
    logic [IDX_W-1:0] at_reg, at_next;
    logic [DEP_W-1:0] dat_reg, dat_next;
    logic [ID_BITS-1:0] par_at_reg, par_at_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [DEP_W-1:0] maxd_reg, maxd_next;
    logic [CNT_W-1:0] ccnt_reg, ccnt_next;
    logic [ID_BITS-1:0] cid_reg, cid_next;
    logic [IDX_W-1:0] pat_reg, pat_next;
    logic [DEP_W-1:0] dpat_reg, dpat_next;
    logic [IDX_W-1:0] ins_reg, ins_next;
    logic [DEP_W-1:0] diff_reg, diff_next;
    out_word_t        res_reg, res_next;
    out_word_t        out_reg, out_next;

    // side buffer for the moved run
    entry_t           tmp_mem [MAX_NODES];
    entry_t           tmp_rd_reg;
    logic             tmp_we;
    logic [IDX_W-1:0] tmp_waddr;
    logic [IDX_W-1:0] tmp_raddr;

    cell_ctrl_t       ctrl;
    entry_t           head;

    logic             accept;
    logic             out_free;
    logic             has_node;
    logic             head_valid;
    logic             hit_node;
    logic             run_cont;
    logic             child_ev;
    logic             hit_par;
    logic [DEP_W:0]   dat_p1;

    // decision
    status_t          dec_status;
    logic [VAL_W-1:0] dec_value;
    logic             dec_edit;
    logic             full;
    logic signed [8:0] diff_w;
    logic signed [8:0] maxnd_w;
    logic [CNT_W-1:0] ins_w;
    logic             inside_run;

    ptt_chain u_chain (
        .aclk (aclk),
        .ctrl (ctrl),
        .head (head)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // watch the head cell during the rotation pass
    assign has_node   = (in_reg.node_id != '0);
    assign head_valid = ({1'b0, i_reg} < cnt_reg);
    assign dat_p1     = {1'b0, dat_reg} + 1'b1;
    assign hit_node   = head_valid && !f_at_reg && has_node && (head.id == in_reg.node_id);
    assign run_cont   = head_valid && in_run_reg && (head.dep > dat_reg);
    assign child_ev   = has_node ? (run_cont && ({1'b0, head.dep} == dat_p1))
                                 : (head_valid && (head.dep == '0));
    assign hit_par    = head_valid && !pf_reg && (in_reg.new_parent != '0)
                        && (head.id == in_reg.new_parent);

    // decide the outcome once the pass is done
    assign full = (cnt_reg >= CNT_W'(MAX_NODES)) || (idctr_reg == '1);

    always_comb begin
        if (in_reg.new_parent != '0) begin
            diff_w = $signed({3'b000, dpat_reg}) + 9'sd1 - $signed({3'b000, dat_reg});
            ins_w  = (pat_reg > at_reg) ? ({1'b0, pat_reg} - n_reg + 1'b1)
                                        : ({1'b0, pat_reg} + 1'b1);
        end else begin
            diff_w = -$signed({3'b000, dat_reg});
            ins_w  = cnt_reg - n_reg;
        end
        maxnd_w    = $signed({3'b000, maxd_reg}) + diff_w;
        inside_run = ({1'b0, pat_reg} >= {1'b0, at_reg})
                     && ({1'b0, pat_reg} < ({1'b0, at_reg} + n_reg));
    end

    always_comb begin
        dec_status = ST_NOTFOUND;
        dec_value  = '0;
        dec_edit   = 1'b0;
        case (in_reg.opcode)
            OP_CREATE: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_status = ST_OK;
                    dec_value  = idctr_reg + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (f_at_reg) begin
                    dec_status = ST_OK;
                    dec_edit   = 1'b1;
                end
            end
            OP_SETPAR: begin
                if (!f_at_reg) begin
                    dec_status = ST_NOTFOUND;
                end else if ((in_reg.new_parent != '0) && !pf_reg) begin
                    dec_status = ST_NOTFOUND;
                end else if ((in_reg.new_parent != '0) && inside_run) begin
                    dec_status = ST_ILLEGAL;
                end else if (maxnd_w > 9'sd63) begin
                    dec_status = ST_ILLEGAL;
                end else begin
                    dec_status = ST_OK;
                    dec_edit   = 1'b1;
                end
            end
            OP_CHCOUNT: begin
                if (!has_node || f_at_reg) begin
                    dec_status = ST_OK;
                    dec_value  = VAL_W'(ccnt_reg);
                end
            end
            OP_DESC: begin
                if (!has_node) begin
                    dec_status = ST_OK;
                    dec_value  = VAL_W'(cnt_reg);
                end else if (f_at_reg) begin
                    dec_status = ST_OK;
                    dec_value  = VAL_W'(n_reg - 1'b1);
                end
            end
            OP_NTH: begin
                if ((!has_node || f_at_reg) && cfound_reg && (cid_reg != '0)) begin
                    dec_status = ST_OK;
                    dec_value  = cid_reg;
                end
            end
            OP_PARENT: begin
                if (f_at_reg) begin
                    dec_status = ST_OK;
                    dec_value  = par_at_reg;
                end
            end
            default: begin
                dec_status = ST_NOTFOUND;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_data.opcode == OP_CREATE) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_reg == IDX_W'(MAX_NODES - 1)) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = dec_edit ? S_SHL : S_RESP;
            end
            S_SHL: begin
                if (k_reg == n_reg - 1'b1) begin
                    state_next = (in_reg.opcode == OP_SETPAR) ? S_SHR : S_RESP;
                end
            end
            S_SHR: begin
                if (k_reg == n_reg - 1'b1) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (k_reg == n_reg) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs: cell control and side buffer port
    always_comb begin
        ctrl.mode = CM_HOLD;
        ctrl.lo   = '0;
        ctrl.wr   = tmp_rd_reg;
        tmp_we    = 1'b0;
        // the node itself lands in slot 0, its run follows in order
        tmp_waddr = hit_node ? '0 : (i_reg - at_reg);
        tmp_raddr = k_reg[IDX_W-1:0];
        case (state_reg)
            S_SCAN: begin
                ctrl.mode = CM_ROT;
                tmp_we    = hit_node || run_cont;
            end
            S_DECIDE: begin
                if ((in_reg.opcode == OP_CREATE) && !full) begin
                    ctrl.mode   = CM_WR;
                    ctrl.lo     = cnt_reg[IDX_W-1:0];
                    ctrl.wr.id  = idctr_reg + 1'b1;
                    ctrl.wr.par = '0;
                    ctrl.wr.dep = '0;
                end
            end
            S_SHL: begin
                ctrl.mode = CM_SHL;
                ctrl.lo   = at_reg;
            end
            S_SHR: begin
                ctrl.mode = CM_SHR;
                ctrl.lo   = ins_reg;
            end
            S_WRITE: begin
                // the buffer read is registered: write entry k-1
                if (k_reg != '0) begin
                    ctrl.mode   = CM_WR;
                    ctrl.lo     = ins_reg + k_reg[IDX_W-1:0] - 1'b1;
                    ctrl.wr.dep = tmp_rd_reg.dep + diff_reg;
                    if (k_reg == CNT_W'(1)) begin
                        ctrl.wr.par = in_reg.new_parent;
                    end
                end
            end
            default: begin
                ctrl.mode = CM_HOLD;
            end
        endcase
    end

    // register next values
    always_comb begin
        in_next      = in_reg;
        cnt_next     = cnt_reg;
        idctr_next   = idctr_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        f_at_next    = f_at_reg;
        in_run_next  = in_run_reg;
        cfound_next  = cfound_reg;
        pf_next      = pf_reg;
        at_next      = at_reg;
        dat_next     = dat_reg;
        par_at_next  = par_at_reg;
        n_next       = n_reg;
        maxd_next    = maxd_reg;
        ccnt_next    = ccnt_reg;
        cid_next     = cid_reg;
        pat_next     = pat_reg;
        dpat_next    = dpat_reg;
        ins_next     = ins_reg;
        diff_next    = diff_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    in_next     = s_data;
                    i_next      = '0;
                    f_at_next   = 1'b0;
                    in_run_next = 1'b0;
                    cfound_next = 1'b0;
                    pf_next     = 1'b0;
                    ccnt_next   = '0;
                end
            end
            S_SCAN: begin
                i_next = i_reg + 1'b1;
                if (hit_node) begin
                    f_at_next   = 1'b1;
                    at_next     = i_reg;
                    dat_next    = head.dep;
                    par_at_next = head.par;
                    in_run_next = 1'b1;
                    n_next      = CNT_W'(1);
                    maxd_next   = head.dep;
                end else if (in_run_reg) begin
                    if (run_cont) begin
                        n_next = n_reg + 1'b1;
                        if (head.dep > maxd_reg) begin
                            maxd_next = head.dep;
                        end
                    end else begin
                        in_run_next = 1'b0;
                    end
                end
                if (child_ev) begin
                    ccnt_next = ccnt_reg + 1'b1;
                    if (!cfound_reg && (ccnt_reg == CNT_W'(in_reg.child_sel))) begin
                        cfound_next = 1'b1;
                        cid_next    = head.id;
                    end
                end
                if (hit_par) begin
                    pf_next   = 1'b1;
                    pat_next  = i_reg;
                    dpat_next = head.dep;
                end
            end
            S_DECIDE: begin
                res_next.ok     = (dec_status == ST_OK);
                res_next.status = dec_status;
                res_next.value  = dec_value;
                k_next          = '0;
                ins_next        = ins_w[IDX_W-1:0];
                diff_next       = diff_w[DEP_W-1:0];
                if ((in_reg.opcode == OP_CREATE) && !full) begin
                    idctr_next = idctr_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (dec_edit && (in_reg.opcode == OP_REMOVE)) begin
                    cnt_next = cnt_reg - n_reg;
                end
            end
            S_SHL, S_SHR: begin
                k_next = (k_reg == n_reg - 1'b1) ? '0 : k_reg + 1'b1;
            end
            S_WRITE: begin
                k_next = k_reg + 1'b1;
            end
            S_RESP: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            idctr_reg   <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
            f_at_reg    <= 1'b0;
            in_run_reg  <= 1'b0;
            cfound_reg  <= 1'b0;
            pf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idctr_reg   <= idctr_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            f_at_reg    <= f_at_next;
            in_run_reg  <= in_run_next;
            cfound_reg  <= cfound_next;
            pf_reg      <= pf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        at_reg     <= at_next;
        dat_reg    <= dat_next;
        par_at_reg <= par_at_next;
        n_reg      <= n_next;
        maxd_reg   <= maxd_next;
        ccnt_reg   <= ccnt_next;
        cid_reg    <= cid_next;
        pat_reg    <= pat_next;
        dpat_reg   <= dpat_next;
        ins_reg    <= ins_next;
        diff_reg   <= diff_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // side buffer: capture the run during the pass, replay it on write-back
    always_ff @(posedge aclk) begin
        if (tmp_we) begin
            tmp_mem[tmp_waddr] <= head;
        end
        tmp_rd_reg <= tmp_mem[tmp_raddr];
    end

endmodule
`default_nettype wire
